// ===== hw/rtl/zipf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zipf_pkg
// Shared types, widths and register codes for the Zipf transaction generator.
// ----------------------------------------------------------------------------
package zipf_pkg;

  // Default sizing
  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_OBJ_LIMIT   = 64;

  // Fixed field widths
  localparam int unsigned THR_W      = 31;  // thresholds and random words
  localparam int unsigned ID_W       = 10;  // object id / entry index
  localparam int unsigned TXN_W      = 32;  // transaction number
  localparam int unsigned TSZ_W      = 11;  // table_size register
  localparam int unsigned CNT_W      = 7;   // per-transaction count registers
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJS_PER_TXN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_READS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_WRITES    = 3'd4;

  // Register reset values
  localparam logic [TSZ_W-1:0] RST_TABLE_SIZE   = 11'd1024;
  localparam logic [CNT_W-1:0] RST_OBJS_PER_TXN = 7'd1;

  // Request codes
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_GENERATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } zipf_state_t;

endpackage

// ===== hw/rtl/zipf_cdf_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zipf_cdf_mem
// Threshold table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module zipf_cdf_mem #(
  parameter int unsigned DEPTH = zipf_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [zipf_pkg::THR_W-1:0]  wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [zipf_pkg::THR_W-1:0]  rd_data
);

  logic [zipf_pkg::THR_W-1:0] mem [DEPTH];
  logic [zipf_pkg::THR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/zipf_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zipf_search
// Binary search for the first entry not below the pick; one probe per cycle.
// ----------------------------------------------------------------------------
module zipf_search #(
  parameter int unsigned DEPTH = zipf_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned NW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NW-1:0]               n_entries,   // already saturated to DEPTH
  input  logic [zipf_pkg::THR_W-1:0]  pick,
  output logic [AW-1:0]               rd_addr,
  input  logic [zipf_pkg::THR_W-1:0]  rd_data,
  output logic                        done,
  output logic [AW-1:0]               result
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [AW-1:0]              lo_r, lo_nxt;
  logic [AW-1:0]              hi_r, hi_nxt;
  logic [AW-1:0]              mid_r, mid_nxt;
  logic [zipf_pkg::THR_W-1:0] pick_r, pick_nxt;

  logic [NW-1:0] n_m1;
  logic [AW-1:0] hi0;
  logic [AW-1:0] step_lo;
  logic [AW-1:0] step_hi;
  logic [AW:0]   step_sum;
  logic          probe_le;

  assign n_m1 = n_entries - NW'(1);
  assign hi0  = n_m1[AW-1:0];

  // Compare the returned entry, narrow the window, form the next probe address.
  assign probe_le = (pick_r <= rd_data);
  assign step_lo  = probe_le ? lo_r : (mid_r + AW'(1));
  assign step_hi  = probe_le ? mid_r : hi_r;
  assign step_sum = {1'b0, step_lo} + {1'b0, step_hi};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    pick_nxt = pick_r;
    rd_addr  = step_sum[AW:1];
    if (start) begin
      pick_nxt = pick;
      lo_nxt   = '0;
      hi_nxt   = hi0;
      mid_nxt  = hi0 >> 1;
      rd_addr  = hi0 >> 1;
      if (n_entries < NW'(2)) begin
        // empty or single-entry table: answer is entry 0
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      lo_nxt  = step_lo;
      hi_nxt  = step_hi;
      mid_nxt = step_sum[AW:1];
      if (step_lo >= step_hi) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    pick_r <= pick_nxt;
  end

  assign done   = done_r;
  assign result = lo_r;

endmodule

// ===== hw/rtl/zipf_transaction_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zipf_transaction_generator
// Zipf inverse-CDF object sampler with read/write transaction framing.
// ----------------------------------------------------------------------------
// Load beat: accepted without a stall; the next input beat can follow immediately.
// Generate beat: the input beat starts a binary search of the table, one table
//   probe per cycle; the found object is then held as the output beat.
//   Input is stalled until the output beat is taken, so the block takes no new
//   input beat while a generate item is in flight.
// Reset (rst_n low, synchronous) clears control and counters, sets the config
//   registers to reset values; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module zipf_transaction_generator #(
  parameter int unsigned TABLE_DEPTH = zipf_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned OBJ_LIMIT   = zipf_pkg::DEF_OBJ_LIMIT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [zipf_pkg::ID_W-1:0]        in_entry_index,
  input  logic [zipf_pkg::THR_W-1:0]       in_cdf_threshold,
  input  logic [zipf_pkg::THR_W-1:0]       in_rand_pick,
  input  logic [zipf_pkg::THR_W-1:0]       in_rand_write,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [zipf_pkg::TXN_W-1:0]       out_txn_number,
  output logic [zipf_pkg::ID_W-1:0]        out_object_id,
  output logic                             out_wr_access,
  output logic                             out_last_in_txn,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [zipf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [zipf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Address and count widths
  localparam int unsigned AW = $clog2(TABLE_DEPTH);        // table address
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);    // entry count
  localparam int unsigned OW = (AW > zipf_pkg::ID_W) ? AW : zipf_pkg::ID_W;
  localparam int unsigned EW = OW + 1;                     // load index compare
  localparam int unsigned TW = (NW > zipf_pkg::TSZ_W) ? NW : zipf_pkg::TSZ_W;
  localparam int unsigned PW = $clog2(OBJ_LIMIT + 1);      // object position
  localparam int unsigned CW = zipf_pkg::CNT_W;

  localparam logic [CW-1:0] MAX_CNT = CW'(OBJ_LIMIT);

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never backpressures.
  // ---------------------------------------------------------------------------
  logic [zipf_pkg::TSZ_W-1:0] tsz_r;
  logic [CW-1:0]              objs_r;
  logic [zipf_pkg::THR_W-1:0] wthr_r;
  logic [CW-1:0]              freads_r;
  logic [CW-1:0]              fwrites_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsz_r     <= zipf_pkg::RST_TABLE_SIZE;
      objs_r    <= zipf_pkg::RST_OBJS_PER_TXN;
      wthr_r    <= '0;
      freads_r  <= '0;
      fwrites_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        zipf_pkg::CFG_TABLE_SIZE:      tsz_r     <= cfg_data[zipf_pkg::TSZ_W-1:0];
        zipf_pkg::CFG_OBJS_PER_TXN:    objs_r    <= cfg_data[CW-1:0];
        zipf_pkg::CFG_WRITE_THRESHOLD: wthr_r    <= cfg_data[zipf_pkg::THR_W-1:0];
        zipf_pkg::CFG_FIXED_READS:     freads_r  <= cfg_data[CW-1:0];
        zipf_pkg::CFG_FIXED_WRITES:    fwrites_r <= cfg_data[CW-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  zipf_pkg::zipf_state_t state_r, state_nxt;

  logic in_acc;
  logic out_acc;
  logic gen_start;
  logic srch_done;
  logic [AW-1:0] srch_obj;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign gen_start = in_acc && (in_req_type == zipf_pkg::REQ_GENERATE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zipf_pkg::ST_IDLE:   if (gen_start) state_nxt = zipf_pkg::ST_SEARCH;
      zipf_pkg::ST_SEARCH: if (srch_done) state_nxt = zipf_pkg::ST_EMIT;
      zipf_pkg::ST_EMIT:   if (out_acc)   state_nxt = zipf_pkg::ST_IDLE;
      default:             state_nxt = zipf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      zipf_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
      end
      zipf_pkg::ST_EMIT: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zipf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Table load path: indexes past the table are dropped.
  // ---------------------------------------------------------------------------
  logic [EW-1:0] load_idx;
  logic          load_en;

  assign load_idx = EW'(in_entry_index);
  assign load_en  = in_acc && (in_req_type == zipf_pkg::REQ_LOAD) &&
                    (load_idx < EW'(TABLE_DEPTH));

  // Search length: table_size clipped to the table depth.
  logic [TW-1:0] tsz_ext;
  logic [NW-1:0] n_sat;

  assign tsz_ext = TW'(tsz_r);
  assign n_sat   = (tsz_ext > TW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : tsz_ext[NW-1:0];

  logic [AW-1:0]              rd_addr;
  logic [zipf_pkg::THR_W-1:0] rd_data;

  zipf_cdf_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (load_idx[AW-1:0]),
    .wr_data (in_cdf_threshold),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  zipf_search #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .NW    (NW)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (gen_start),
    .n_entries (n_sat),
    .pick      (in_rand_pick),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .done      (srch_done),
    .result    (srch_obj)
  );

  // ---------------------------------------------------------------------------
  // Transaction framing: read/write and last flags settle at the input beat.
  // The user must keep config quiet while an item is in flight (unenforced).
  // ---------------------------------------------------------------------------
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [zipf_pkg::TXN_W-1:0] txn_r, txn_nxt;
  logic                       wr_r, wr_nxt;
  logic                       last_r, last_nxt;
  logic [OW-1:0]              obj_r, obj_nxt;

  logic          fixed_mode;
  logic [CW-1:0] fr_sat;
  logic [CW-1:0] fw_room;
  logic [CW-1:0] fw_sat;
  logic [CW-1:0] fixed_len;
  logic [CW-1:0] prob_len;
  logic [CW-1:0] txn_len;
  logic [CW-1:0] pos_ext;
  logic [CW:0]   pos_inc;

  assign fixed_mode = (freads_r != '0) || (fwrites_r != '0);
  assign fr_sat     = (freads_r > MAX_CNT) ? MAX_CNT : freads_r;
  assign fw_room    = MAX_CNT - fr_sat;
  assign fw_sat     = (fwrites_r > fw_room) ? fw_room : fwrites_r;
  assign fixed_len  = ((fr_sat + fw_sat) == '0) ? CW'(1) : (fr_sat + fw_sat);

  always_comb begin
    priority if (objs_r == '0) begin
      prob_len = CW'(1);
    end else if (objs_r > MAX_CNT) begin
      prob_len = MAX_CNT;
    end else begin
      prob_len = objs_r;
    end
  end

  assign txn_len = fixed_mode ? fixed_len : prob_len;
  assign pos_ext = CW'(pos_r);
  assign pos_inc = {1'b0, pos_ext} + (CW + 1)'(1);

  always_comb begin
    wr_nxt   = wr_r;
    last_nxt = last_r;
    obj_nxt  = obj_r;
    pos_nxt  = pos_r;
    txn_nxt  = txn_r;
    if (gen_start) begin
      wr_nxt   = fixed_mode ? (pos_ext >= fr_sat) : (in_rand_write < wthr_r);
      last_nxt = (pos_inc >= {1'b0, txn_len});
    end
    if (srch_done) begin
      obj_nxt = OW'(srch_obj);
    end
    if (out_acc) begin
      if (last_r) begin
        pos_nxt = '0;
        txn_nxt = txn_r + zipf_pkg::TXN_W'(1);
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      txn_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      txn_r <= txn_nxt;
    end
    wr_r   <= wr_nxt;
    last_r <= last_nxt;
    obj_r  <= obj_nxt;
  end

  assign out_txn_number  = txn_r;
  assign out_object_id   = obj_r[zipf_pkg::ID_W-1:0];
  assign out_wr_access   = wr_r;
  assign out_last_in_txn = last_r;

endmodule

// ===== test/zipf_transaction_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zipf_transaction_generator_tb
// Self-checking bench: loads the CDF table, then drives directed and random
// generate/load beats through several register settings. A scoreboard class
// predicts each object beat and compares it field by field with the result
// channel. Both channels see random idling and stalls.
// ----------------------------------------------------------------------------
module zipf_transaction_generator_tb;
  import zipf_pkg::*;

  localparam int unsigned TABLE_DEPTH   = DEF_TABLE_DEPTH;
  localparam int unsigned OBJ_LIMIT     = DEF_OBJ_LIMIT;
  localparam logic [THR_W-1:0] THR_MAX  = '1;
  // Extra idle cycles after the last result in settle(); leave margin.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RANDOM_BEATS  = 920;
  localparam int unsigned RUN_LIMIT_NS  = 2_000_000;
  // Indexes past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_FIXED_WRITES + 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [ID_W-1:0]  entry_index;
    logic [THR_W-1:0] cdf_threshold;
    logic [THR_W-1:0] rand_pick;
    logic [THR_W-1:0] rand_write;
  } zipf_req_t;

  typedef struct packed {
    logic [TXN_W-1:0] txn_number;
    logic [ID_W-1:0]  object_id;
    logic             wr_access;
    logic             last_in_txn;
  } zipf_obj_t;

  // Receiver stall behavior, re-chosen every so often.
  typedef enum int unsigned {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of table, registers and transaction framing state.
  // --------------------------------------------------------------------------
  class zipf_scoreboard;
    logic [THR_W-1:0] thr_table [TABLE_DEPTH];
    logic [TSZ_W-1:0] table_size;
    logic [CNT_W-1:0] objs_per_txn;
    logic [THR_W-1:0] write_thr;
    logic [CNT_W-1:0] fixed_reads;
    logic [CNT_W-1:0] fixed_writes;
    int unsigned      obj_pos;
    logic [TXN_W-1:0] txn_count;
    zipf_obj_t        expected_objects [$];
    int unsigned      errors;

    function new();
      table_size   = RST_TABLE_SIZE;
      objs_per_txn = RST_OBJS_PER_TXN;
      write_thr    = '0;
      fixed_reads  = '0;
      fixed_writes = '0;
      obj_pos      = 0;
      txn_count    = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TABLE_SIZE:      table_size   = data[TSZ_W-1:0];
        CFG_OBJS_PER_TXN:    objs_per_txn = data[CNT_W-1:0];
        CFG_WRITE_THRESHOLD: write_thr    = data[THR_W-1:0];
        CFG_FIXED_READS:     fixed_reads  = data[CNT_W-1:0];
        CFG_FIXED_WRITES:    fixed_writes = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // First entry whose threshold is not below the pick; last searched entry
    // if none qualifies.
    function logic [ID_W-1:0] sample_object(logic [THR_W-1:0] pick);
      int unsigned n, lo, hi, mid;
      n = (table_size > TABLE_DEPTH) ? TABLE_DEPTH : table_size;
      if (n == 0) return '0;
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (pick <= thr_table[mid]) hi = mid;
        else lo = mid + 1;
      end
      return lo[ID_W-1:0];
    endfunction

    function void take_request(zipf_req_t b);
      int unsigned r, w, len;
      logic        wr, last;
      zipf_obj_t   obj;
      if (b.req_type == REQ_LOAD) begin
        thr_table[b.entry_index] = b.cdf_threshold;
        return;
      end
      if (fixed_reads != 0 || fixed_writes != 0) begin
        r   = (fixed_reads > OBJ_LIMIT) ? OBJ_LIMIT : fixed_reads;
        w   = (fixed_writes > OBJ_LIMIT - r) ? OBJ_LIMIT - r : fixed_writes;
        len = (r + w == 0) ? 1 : r + w;
        wr  = (obj_pos >= r);
      end else begin
        len = (objs_per_txn == 0) ? 1 : objs_per_txn;
        if (len > OBJ_LIMIT) len = OBJ_LIMIT;
        wr  = (b.rand_write < write_thr);
      end
      last = (obj_pos + 1 >= len);
      obj.txn_number  = txn_count;
      obj.object_id   = sample_object(b.rand_pick);
      obj.wr_access   = wr;
      obj.last_in_txn = last;
      expected_objects.push_back(obj);
      if (last) begin
        obj_pos   = 0;
        txn_count = txn_count + 1'b1;
      end else begin
        obj_pos = (obj_pos + 1) & 'h7F;
      end
    endfunction

    function void check_object(zipf_obj_t got);
      zipf_obj_t want;
      if (expected_objects.size() == 0) begin
        $error("object beat with nothing expected: txn %0d id %0d",
               got.txn_number, got.object_id);
        errors++;
        return;
      end
      want = expected_objects.pop_front();
      if (got.txn_number !== want.txn_number) begin
        $error("txn_number: expected %0d, got %0d", want.txn_number, got.txn_number);
        errors++;
      end
      if (got.object_id !== want.object_id) begin
        $error("object_id: expected %0d, got %0d", want.object_id, got.object_id);
        errors++;
      end
      if (got.wr_access !== want.wr_access) begin
        $error("wr_access: expected %0b, got %0b", want.wr_access, got.wr_access);
        errors++;
      end
      if (got.last_in_txn !== want.last_in_txn) begin
        $error("last_in_txn: expected %0b, got %0b", want.last_in_txn, got.last_in_txn);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_objects.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // All block inputs start at known values.
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_req_type      = 1'b0;
  logic [ID_W-1:0]       in_entry_index   = '0;
  logic [THR_W-1:0]      in_cdf_threshold = '0;
  logic [THR_W-1:0]      in_rand_pick     = '0;
  logic [THR_W-1:0]      in_rand_write    = '0;
  logic                  out_stall        = 1'b0;
  logic                  cfg_valid        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [TXN_W-1:0]      out_txn_number;
  logic [ID_W-1:0]       out_object_id;
  logic                  out_wr_access;
  logic                  out_last_in_txn;
  logic                  cfg_ready;

  zipf_transaction_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_entry_index   (in_entry_index),
    .in_cdf_threshold (in_cdf_threshold),
    .in_rand_pick     (in_rand_pick),
    .in_rand_write    (in_rand_write),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_txn_number   (out_txn_number),
    .out_object_id    (out_object_id),
    .out_wr_access    (out_wr_access),
    .out_last_in_txn  (out_last_in_txn),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  zipf_scoreboard sb = new();

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the NBAs of that
  // edge land, so it sees exactly what the block saw.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.take_request({in_req_type, in_entry_index, in_cdf_threshold,
                         in_rand_pick, in_rand_write});
      if (out_valid && !out_stall)
        sb.check_object({out_txn_number, out_object_id, out_wr_access, out_last_in_txn});
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern independent of the sender. The mode is re-chosen
  // periodically: free-running, light random, heavy random, or a fixed one-third duty.
  // --------------------------------------------------------------------------
  int unsigned rx_cycle = 0;
  rx_mode_t    rx_mode  = RX_FREE;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 150 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= ((rx_cycle / 9) % 3 == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of beats with random gaps; a phase may run gapless.
  // tx_active tracks in_valid so it is only lowered once per step.
  // --------------------------------------------------------------------------
  bit          tx_active     = 1'b0;
  bit          tx_gapless    = 1'b0;
  int unsigned tx_burst_left = 1;

  task automatic stop_stream();
    if (tx_active) begin
      in_valid  <= 1'b0;
      tx_active = 1'b0;
    end
  endtask

  task automatic send_beat(input zipf_req_t b);
    in_valid         <= 1'b1;
    in_req_type      <= b.req_type;
    in_entry_index   <= b.entry_index;
    in_cdf_threshold <= b.cdf_threshold;
    in_rand_pick     <= b.rand_pick;
    in_rand_write    <= b.rand_write;
    tx_active = 1'b1;
    do @(posedge clk); while (in_stall);
    if (!tx_gapless) begin
      if (tx_burst_left > 0) tx_burst_left--;
      if (tx_burst_left == 0) begin
        // gap long enough to land on any cycle of a search
        stop_stream();
        repeat ($urandom_range(1, 14)) @(posedge clk);
        tx_burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic load_entry(input logic [ID_W-1:0] idx, input logic [THR_W-1:0] thr);
    zipf_req_t b;
    b = {REQ_LOAD, idx, thr, THR_W'($urandom()), THR_W'($urandom())};
    send_beat(b);
  endtask

  task automatic gen_object(input logic [THR_W-1:0] pick, input logic [THR_W-1:0] rw);
    zipf_req_t b;
    b = {REQ_GENERATE, ID_W'($urandom()), THR_W'($urandom()), pick, rw};
    send_beat(b);
  endtask

  // Random beat; picks and write words lean toward the comparison edges.
  task automatic random_beat(input int unsigned load_pct);
    zipf_req_t b;
    b.req_type      = ($urandom_range(0, 99) < load_pct) ? REQ_LOAD : REQ_GENERATE;
    b.entry_index   = ID_W'($urandom());
    b.cdf_threshold = THR_W'($urandom());
    case ($urandom_range(0, 7))
      0:       b.rand_pick = '0;
      1:       b.rand_pick = THR_MAX;
      2:       b.rand_pick = sb.thr_table[$urandom_range(0, TABLE_DEPTH - 1)];
      3:       b.rand_pick = sb.thr_table[$urandom_range(0, TABLE_DEPTH - 1)] + 1'b1;
      default: b.rand_pick = THR_W'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0:       b.rand_write = sb.write_thr;
      1:       b.rand_write = sb.write_thr - 1'b1;
      2:       b.rand_write = '0;
      3:       b.rand_write = THR_MAX;
      default: b.rand_write = THR_W'($urandom());
    endcase
    send_beat(b);
  endtask

  // Block idle: no results outstanding, and any load in flight has finished.
  // It first waits for the monitor to log the last accepted beat.
  task automatic settle();
    stop_stream();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Config channel. Writes go back to back; valid drops after the last one.
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Sometimes junk goes in the unused upper data bits of the narrow registers.
  task automatic apply_config(input logic [TSZ_W-1:0] tsize, input logic [CNT_W-1:0] objs,
                              input logic [THR_W-1:0] wthr, input logic [CNT_W-1:0] freads,
                              input logic [CNT_W-1:0] fwrites, input bit spare);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
    cfg_write(CFG_TABLE_SIZE, (junk << TSZ_W) | tsize);
    cfg_write(CFG_OBJS_PER_TXN, (junk << CNT_W) | objs);
    cfg_write(CFG_WRITE_THRESHOLD, wthr);
    cfg_write(CFG_FIXED_READS, (junk << CNT_W) | freads);
    cfg_write(CFG_FIXED_WRITES, (junk << CNT_W) | fwrites);
    if (spare)
      for (int i = CFG_FIRST_SPARE; i < (1 << CFG_IDX_W); i++)
        cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned      random_beats;
    int unsigned      phase_len;
    int unsigned      load_pct;
    logic [TSZ_W-1:0] ts;
    logic [CNT_W-1:0] opt, fr, fw;
    logic [THR_W-1:0] wt;
    logic [THR_W-1:0] level;

    random_beats = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every entry with a rising CDF so no search ever reads an unwritten
    // entry. Entry 0 holds zero, the last entry the full-scale value.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) level = '0;
      else if (i == TABLE_DEPTH - 1) level = THR_MAX;
      else level = THR_W'((i << (THR_W - ID_W)) |
                          ($urandom() & ((1 << (THR_W - ID_W)) - 1)));
      load_entry(ID_W'(i), level);
    end

    // Directed: search edges on the reset configuration (full table).
    gen_object('0, '0);                             // pick zero hits entry 0
    gen_object(THR_MAX, THR_MAX);                   // full-scale pick
    gen_object(sb.thr_table[512], THR_W'($urandom()));  // pick equal to a threshold
    gen_object(sb.thr_table[511] + 1'b1, THR_W'($urandom()));
    settle();

    // Probabilistic write decision at the top threshold; 3-object transactions.
    apply_config(TSZ_W'(TABLE_DEPTH), 3, THR_MAX, 0, 0, 1'b0);
    gen_object(THR_W'($urandom()), THR_MAX);                // not below: read
    gen_object(THR_W'($urandom()), THR_MAX - 1'b1);         // below: write
    gen_object(THR_W'($urandom()), '0);
    settle();

    // Empty table answers 0; objects per transaction saturates to the max.
    apply_config('0, '1, '0, 0, 0, 1'b0);
    gen_object(THR_MAX, THR_W'($urandom()));
    gen_object(THR_W'($urandom()), THR_W'($urandom()));
    settle();
    // Oversized table clamps to the real depth.
    apply_config('1, '1, '0, 0, 0, 1'b0);
    gen_object(THR_MAX, THR_W'($urandom()));
    settle();
    // One-entry table; no entry reaches the pick.
    apply_config(1, '1, '0, 0, 0, 1'b0);
    gen_object(THR_MAX, THR_W'($urandom()));
    settle();
    // Shrink mid-transaction: position 4 already past a length of 2.
    apply_config(TSZ_W'(TABLE_DEPTH), 2, '0, 0, 0, 1'b1);
    gen_object(THR_W'($urandom()), THR_W'($urandom()));
    gen_object(THR_W'($urandom()), THR_W'($urandom()));
    gen_object(THR_W'($urandom()), THR_W'($urandom()));
    settle();
    // Fixed mode, both counts oversized: 64 reads, no writes.
    apply_config(TSZ_W'(TABLE_DEPTH), 1, THR_MAX, '1, '1, 1'b0);
    gen_object(THR_W'($urandom()), '0);
    gen_object(THR_W'($urandom()), '0);
    settle();
    // Fixed 1 read + 2 writes; rand_write must not matter.
    apply_config(TSZ_W'(TABLE_DEPTH), 1, THR_MAX, 1, 2, 1'b0);
    repeat (4) gen_object(THR_W'($urandom()), '0);
    settle();
    // Writes only.
    apply_config(TSZ_W'(TABLE_DEPTH), 1, '0, 0, CNT_W'(OBJ_LIMIT), 1'b1);
    gen_object('0, THR_W'($urandom()));
    gen_object(THR_MAX, THR_W'($urandom()));

    // Random phases: new settings each time, then a burst of mostly generates
    // with some table reloads mixed in.
    while (random_beats < RANDOM_BEATS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       ts = '0;
        1:       ts = 1;
        2:       ts = TSZ_W'($urandom_range(2, 8));
        3:       ts = TSZ_W'(TABLE_DEPTH);
        4:       ts = TSZ_W'($urandom_range(TABLE_DEPTH + 1, (1 << TSZ_W) - 1));
        default: ts = TSZ_W'($urandom_range(1, TABLE_DEPTH));
      endcase
      case ($urandom_range(0, 7))
        0:       opt = '0;
        1:       opt = '1;
        2:       opt = CNT_W'(OBJ_LIMIT);
        3, 4:    opt = CNT_W'($urandom_range(1, 8));
        default: opt = CNT_W'($urandom_range(1, OBJ_LIMIT));
      endcase
      case ($urandom_range(0, 3))
        0:       wt = '0;
        1:       wt = THR_MAX;
        default: wt = THR_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
        6: begin
          fr = CNT_W'($urandom_range(0, OBJ_LIMIT));
          fw = CNT_W'($urandom_range(0, OBJ_LIMIT));
        end
        7: begin
          fr = 0;
          fw = CNT_W'($urandom_range(1, 8));
        end
        8: begin
          fr = CNT_W'($urandom_range(1, 8));
          fw = 0;
        end
        9: begin
          fr = CNT_W'($urandom());
          fw = CNT_W'($urandom());
        end
        default: begin
          fr = 0;
          fw = 0;
        end
      endcase
      apply_config(ts, opt, wt, fr, fw, $urandom_range(0, 7) == 0);

      tx_gapless    = ($urandom_range(0, 3) == 0);
      tx_burst_left = $urandom_range(1, 12);
      load_pct      = $urandom_range(0, 25);
      phase_len     = $urandom_range(25, 50);
      for (int j = 0; j < phase_len; j++) begin
        random_beat(load_pct);
        random_beats++;
        // Occasionally hold off until the pipe has fully drained.
        if ($urandom_range(0, 49) == 0) begin
          stop_stream();
          @(posedge clk);
          while (sb.pending() != 0) @(posedge clk);
        end
      end
    end

    settle();
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
